>>> rtl/slbcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbcs_pkg
// Types, constants and blink pattern tables for the status LED sequencer.
// ----------------------------------------------------------------------------
package slbcs_pkg;

  localparam int unsigned PATTERN_STEPS = 11;
  localparam int unsigned STEP_W        = 4;
  localparam int unsigned GROUP_W       = 4;
  localparam int unsigned FLAG_W        = 8;

  localparam logic [GROUP_W-1:0] GAP_GROUP  = GROUP_W'(8);
  localparam logic [STEP_W-1:0]  LIT_STEPS  = STEP_W'(7);
  localparam logic [STEP_W-1:0]  STEP_LIMIT = STEP_W'(PATTERN_STEPS - 1);
  localparam logic [STEP_W-1:0]  GAP_LIMIT  = STEP_W'((PATTERN_STEPS - 1) / 2);

  typedef struct packed {
    logic [GROUP_W-1:0] group_index;
    logic [STEP_W-1:0]  step_count;
    logic               red;
    logic               green;
  } seq_state_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic pins_written;
  } seq_result_t;

  // bit k = LED lit on step k
  function automatic logic [7:0] red_mask(input logic [GROUP_W-1:0] grp);
    logic [7:0] m;
    case (grp)
      4'd1, 4'd2, 4'd3, 4'd4: m = 8'h55;
      4'd6, 4'd7:             m = 8'h7F;
      default:                m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] green_mask(input logic [GROUP_W-1:0] grp);
    logic [7:0] m;
    case (grp)
      4'd0, 4'd7: m = 8'h7F;
      4'd2:       m = 8'h44;
      4'd3:       m = 8'h50;
      4'd4, 4'd5: m = 8'h55;
      default:    m = 8'h00;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/status_led_blink_code_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// status_led_blink_code_sequencer
// Blink-code sequencer for a red/green status LED pair.
//
// Input channel: one eight-bit status word per transfer (in_status_flags),
// one per LED update tick. Result channel: one result per input transfer,
// carrying the red and green levels and whether the pins were written.
// The result of a transfer appears in the output register on the next
// cycle. Throughput is one item per cycle while in_stall is low; the whole
// tick (group scan, pattern lookup, step advance) is one level of logic
// between the sequencer state and the output register.
// While the receiver stalls, the output register holds its result and the
// input is stalled only if that register is full and not being taken.
// Reset (synchronous, rst_n low) sets group and step to zero, both LEDs
// off and empties the output register. No clearing pass is needed.
// ----------------------------------------------------------------------------
module status_led_blink_code_sequencer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_status_flags,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       out_red_on,
  output      logic       out_green_on,
  output      logic       out_pins_written
);

  slbcs_pkg::seq_state_t  state_r;
  slbcs_pkg::seq_state_t  state_nxt;
  slbcs_pkg::seq_result_t res_nxt;
  slbcs_pkg::seq_result_t res_r;
  logic                   out_valid_r;
  logic                   in_xfer;

  slbcs_step u_step (
    .status_flags (in_status_flags),
    .cur          (state_r),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_on       = res_r.red_on;
  assign out_green_on     = res_r.green_on;
  assign out_pins_written = res_r.pins_written;

endmodule
`default_nettype wire

>>> rtl/slbcs_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbcs_step
// One tick of the sequencer: group scan, pattern lookup and state advance.
// ----------------------------------------------------------------------------
module slbcs_step (
  input  wire logic [slbcs_pkg::FLAG_W-1:0] status_flags,
  input  wire slbcs_pkg::seq_state_t        cur,
  output slbcs_pkg::seq_state_t             nxt,
  output slbcs_pkg::seq_result_t            res
);

  logic [slbcs_pkg::FLAG_W-1:0]  cand;
  logic [slbcs_pkg::GROUP_W-1:0] taken;
  logic                          found;
  logic [slbcs_pkg::STEP_W-1:0]  s_eff;
  logic [slbcs_pkg::STEP_W-1:0]  s_inc;
  logic [slbcs_pkg::STEP_W-1:0]  limit;
  logic [7:0]                    rmask;
  logic [7:0]                    gmask;
  logic                          red;
  logic                          green;

  // flags at or above the current group
  always_comb begin
    for (int k = 0; k < slbcs_pkg::FLAG_W; k++) begin
      cand[k] = status_flags[k] && (slbcs_pkg::GROUP_W'(k) >= cur.group_index);
    end
  end

  // lowest candidate wins, gap when none
  always_comb begin
    taken = slbcs_pkg::GAP_GROUP;
    found = 1'b0;
    for (int k = 0; k < slbcs_pkg::FLAG_W; k++) begin
      if (cand[k] && !found) begin
        taken = slbcs_pkg::GROUP_W'(k);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    s_eff = (cur.step_count >= slbcs_pkg::STEP_LIMIT) ? '0 : cur.step_count;
    rmask = slbcs_pkg::red_mask(taken);
    gmask = slbcs_pkg::green_mask(taken);
    red   = (s_eff < slbcs_pkg::LIT_STEPS) && rmask[s_eff[2:0]];
    green = (s_eff < slbcs_pkg::LIT_STEPS) && gmask[s_eff[2:0]];
    s_inc = s_eff + slbcs_pkg::STEP_W'(1);
    limit = (taken == slbcs_pkg::GAP_GROUP) ? slbcs_pkg::GAP_LIMIT : slbcs_pkg::STEP_LIMIT;

    if (cur.group_index > slbcs_pkg::GAP_GROUP) begin
      // wrap tick: back to group 0, pins untouched
      nxt.group_index  = '0;
      nxt.step_count   = '0;
      nxt.red          = cur.red;
      nxt.green        = cur.green;
      res.red_on       = cur.red;
      res.green_on     = cur.green;
      res.pins_written = 1'b0;
    end else begin
      nxt.group_index  = (s_inc >= limit) ? taken + slbcs_pkg::GROUP_W'(1) : taken;
      nxt.step_count   = s_inc;
      nxt.red          = red;
      nxt.green        = green;
      res.red_on       = red;
      res.green_on     = green;
      res.pins_written = 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> tb/status_led_blink_code_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_blink_code_sequencer_test
// Self-checking bench for the status LED blink-code sequencer. Status words
// are sent as directed cases, then as runs of held flag patterns with random
// content and some noise. A tracker class keeps its own copy of the group,
// step and LED state. It predicts the LED levels for every input transfer and
// checks each output transfer in order. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module status_led_blink_code_sequencer_test;

  localparam int unsigned ITEM_COUNT      = 1350;
  localparam int unsigned QUIET_TAIL      = 150;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;

  class blink_code_tracker;
    localparam int unsigned MAX_SHOWN = 50;

    typedef enum logic [3:0] {
      GRP_GOOD       = 4'd0,
      GRP_LOW_BATT   = 4'd1,
      GRP_HOT_BATT   = 4'd2,
      GRP_OBJECT     = 4'd3,
      GRP_END_TRAVEL = 4'd4,
      GRP_NO_SETPT   = 4'd5,
      GRP_EMERGENCY  = 4'd6,
      GRP_NO_COMMS   = 4'd7
    } status_group_t;

    logic [3:0]             group_q;
    logic [3:0]             step_q;
    logic                   red_q;
    logic                   green_q;
    slbcs_pkg::seq_result_t expected_leds[$];
    int unsigned            errors;

    function new();
      group_q = '0;
      step_q  = '0;
      red_q   = 1'b0;
      green_q = 1'b0;
      errors  = 0;
    endfunction

    function int pending();
      return expected_leds.size();
    endfunction

    function void note_status(logic [7:0] flags);
      logic [3:0]             grp;
      logic [3:0]             stp;
      logic [3:0]             lim;
      logic [15:0]            pats;
      slbcs_pkg::seq_result_t res;
      grp = group_q;
      stp = step_q;
      if (grp > slbcs_pkg::GAP_GROUP) begin
        // wrap tick: back to the first group, pins left as they were
        group_q          = '0;
        step_q           = '0;
        res.red_on       = red_q;
        res.green_on     = green_q;
        res.pins_written = 1'b0;
      end else begin
        while (grp < slbcs_pkg::GAP_GROUP && !flags[grp[2:0]])
          grp = grp + 4'd1;
        if (stp >= 4'(slbcs_pkg::PATTERN_STEPS - 1))
          stp = '0;
        // {red steps, green steps}, bit k lit on step k
        case (grp)
          GRP_GOOD:       pats = 16'h007F;
          GRP_LOW_BATT:   pats = 16'h5500;
          GRP_HOT_BATT:   pats = 16'h5544;
          GRP_OBJECT:     pats = 16'h5550;
          GRP_END_TRAVEL: pats = 16'h5555;
          GRP_NO_SETPT:   pats = 16'h0055;
          GRP_EMERGENCY:  pats = 16'h7F00;
          GRP_NO_COMMS:   pats = 16'h7F7F;
          default:        pats = 16'h0000;
        endcase
        red_q   = (stp < slbcs_pkg::LIT_STEPS) ? pats[8 + stp[2:0]] : 1'b0;
        green_q = (stp < slbcs_pkg::LIT_STEPS) ? pats[stp[2:0]] : 1'b0;
        stp = stp + 4'd1;
        lim = (grp == slbcs_pkg::GAP_GROUP) ? 4'((slbcs_pkg::PATTERN_STEPS - 1) / 2)
                                            : 4'(slbcs_pkg::PATTERN_STEPS - 1);
        if (stp >= lim)
          grp = grp + 4'd1;
        group_q          = grp;
        step_q           = stp;
        res.red_on       = red_q;
        res.green_on     = green_q;
        res.pins_written = 1'b1;
      end
      expected_leds.push_back(res);
    endfunction

    task report(string what);
      errors++;
      // keep the log short if the block is badly off
      if (errors <= MAX_SHOWN)
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_leds(logic red, logic green, logic pins);
      slbcs_pkg::seq_result_t want;
      if (expected_leds.size() == 0) begin
        report($sformatf("unexpected transfer red=%b green=%b written=%b", red, green, pins));
        return;
      end
      want = expected_leds.pop_front();
      if (red !== want.red_on)
        report($sformatf("red_on %b, expected %b", red, want.red_on));
      if (green !== want.green_on)
        report($sformatf("green_on %b, expected %b", green, want.green_on));
      if (pins !== want.pins_written)
        report($sformatf("pins_written %b, expected %b", pins, want.pins_written));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_status_flags;
  logic       out_valid;
  logic       out_stall;
  logic       out_red_on;
  logic       out_green_on;
  logic       out_pins_written;

  blink_code_tracker tracker = new();
  bit          quiet         = 1'b0;
  bit          hold_off_req  = 1'b0;
  int unsigned idle_cycles   = 0;

  status_led_blink_code_sequencer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_status_flags  (in_status_flags),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red_on       (out_red_on),
    .out_green_on     (out_green_on),
    .out_pins_written (out_pins_written)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_status(input logic [7:0] flags);
    @(negedge clk);
    in_valid        = 1'b1;
    in_status_flags = flags;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_gap(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid        = 1'b0;
      in_status_flags = 8'($urandom);
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(0, 9);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // transfer monitor and watchdog
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      idle_cycles++;
      if (rst_n) begin
        if (in_valid && !in_stall) begin
          tracker.note_status(in_status_flags);
          idle_cycles = 0;
        end
        if (out_valid === 1'b1 && !out_stall) begin
          tracker.check_leds(out_red_on, out_green_on, out_pins_written);
          idle_cycles = 0;
        end
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned run_left;
    int unsigned style;
    logic [7:0]  run_flags;
    in_valid        = 1'b0;
    in_status_flags = 8'h00;
    rst_n           = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // dark gap then wrap, full good pattern into step restart, each flag alone
    repeat (6) send_status(8'h00);
    repeat (12) send_status(8'hFF);
    for (int k = 0; k < 8; k++)
      send_status(8'(1) << k);
    sent = 26;

    run_left  = 0;
    style     = 0;
    run_flags = 8'h00;
    while (sent < ITEM_COUNT) begin
      if (run_left == 0) begin
        style    = $urandom_range(0, 9);
        run_left = $urandom_range(1, 40);
        case (style)
          0, 1, 2, 3: begin
            run_flags = 8'(1) << $urandom_range(0, 7);
            if ($urandom_range(0, 1) == 1)
              run_flags = run_flags | (8'(1) << $urandom_range(0, 7));
          end
          7:       run_flags = 8'h00;
          8:       run_flags = 8'hFF;
          default: run_flags = 8'($urandom);
        endcase
      end
      if (sent == 400)
        hold_off_req = 1'b1;
      if (sent == 800) begin
        // let the block drain completely before carrying on
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
      end
      quiet = (sent >= ITEM_COUNT - QUIET_TAIL);
      send_status((style == 9) ? 8'($urandom) : run_flags);
      run_left--;
      sent++;
      if (!quiet && $urandom_range(0, 5) == 0)
        sender_gap($urandom_range(1, 10));
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
